FILE: hw/rtl/maxpool_3x3_stream_defines.svh
// Assertion macros shared by the max pooling RTL files.
`ifndef MAXPOOL_3X3_STREAM_DEFINES_SVH
`define MAXPOOL_3X3_STREAM_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define MP3_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("maxpool_3x3_stream: check failed");

// Property checked at every clock edge, reset included.
`define MP3_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("maxpool_3x3_stream: check failed");

`endif

FILE: hw/rtl/mp3_pkg.sv
// Package: shared types, register codes and the binary32 maximum.
`default_nettype none
package mp3_pkg;

  localparam logic [31:0] CANON_NAN = 32'h7fc00000;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_IN_COLS  = 3'd0;
  localparam logic [2:0] REG_IN_ROWS  = 3'd1;
  localparam logic [2:0] REG_OUT_COLS = 3'd2;
  localparam logic [2:0] REG_OUT_ROWS = 3'd3;
  localparam logic [2:0] REG_CHANNELS = 3'd4;
  localparam logic [2:0] REG_STRIDE   = 3'd5;

  // One result transaction
  typedef struct packed {
    logic [31:0] max_bits;
    logic        row_end;
    logic        channel_end;
  } mp3_result_t;

  function automatic logic is_nan(input logic [31:0] b);
    return b[30:0] > 31'h7f800000;
  endfunction

  // Maps binary32 onto an unsigned key with the same order (-0 below +0)
  function automatic logic [31:0] order_key(input logic [31:0] b);
    return b[31] ? ~b : (b | 32'h80000000);
  endfunction

  // maximumNumber: NaN loses to a number, two NaNs give the canonical NaN
  function automatic logic [31:0] fmax_bits(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] r;
    if (is_nan(a)) r = is_nan(b) ? CANON_NAN : b;
    else if (is_nan(b)) r = a;
    else r = (order_key(a) >= order_key(b)) ? a : b;
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/mp3_line_mem.sv
// Two line stores packed into one word: older row in the upper half, newer in the lower.
`default_nettype none
module mp3_line_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic          clk_i,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output logic [63:0]        rd_data_o,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire logic [63:0]   wr_data_i
);

  logic [63:0] mem [DEPTH];
  logic [63:0] rd_data_q;

  // Synchronous write
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

FILE: hw/rtl/mp3_out_fifo.sv
// Three-entry result queue between the compute stage and the output channel.
`default_nettype none
`include "maxpool_3x3_stream_defines.svh"
module mp3_out_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire mp3_pkg::mp3_result_t push_data_i,
  output logic [1:0]              count_o,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output mp3_pkg::mp3_result_t    data_o
);
  import mp3_pkg::*;

  localparam logic [1:0] DEPTH = 2'd3;

  mp3_result_t entry_q [3];
  logic [1:0]  rd_ptr_q, rd_ptr_d;
  logic [1:0]  wr_ptr_q, wr_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (count_q != 2'd0);
  assign count_o = count_q;
  assign data_o  = entry_q[rd_ptr_q];

  // Pointer and fill update
  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    count_d  = count_q;
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == DEPTH - 2'd1) ? 2'd0 : rd_ptr_q + 2'd1;
    end
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == DEPTH - 2'd1) ? 2'd0 : wr_ptr_q + 2'd1;
    end
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= 2'd0;
      wr_ptr_q <= 2'd0;
      count_q  <= 2'd0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
    end
  end

  // Payload storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  `MP3_ASSERT(a_no_overflow, clk_i, rst_ni, (push_i && !pop) |-> (count_q < DEPTH))
  `MP3_ASSERT(a_count_range, clk_i, rst_ni, count_q <= DEPTH)
  `MP3_ASSERT(a_count_track, clk_i, rst_ni,
              (pop && !push_i) |=> (count_q == $past(count_q) - 2'd1))

endmodule
`default_nettype wire

FILE: hw/rtl/maxpool_3x3_stream.sv
// Top level: streaming 3x3 max pooling over binary32 samples with stride 1 to 3.
`default_nettype none
`include "maxpool_3x3_stream_defines.svh"
// Samples enter in raster order, channel after channel, one transaction per clock when
// the output side keeps up. The edge that accepts a sample reads the two stored rows
// for its column from a single line memory, and the next cycle forms the column
// maximum, writes the column back and finishes the window. Window results wait in a
// three-entry queue, so the input keeps streaming while results are held until the
// queue is close to full. A result marks the last window of a row (row_end) and of a
// channel (channel_end). Output count per row and per channel is out_cols / out_rows,
// cut to what fits the input. The user must write configuration over the APB port only
// while no transaction is in flight; the block itself does not enforce this.
module maxpool_3x3_stream #(
  parameter int MAX_COLS     = 1024,
  parameter int MAX_ROWS     = 1024,
  parameter int MAX_CHANNELS = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] sample_bits_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      max_bits_o,
  output logic             row_end_o,
  output logic             channel_end_o
);
  import mp3_pkg::*;

  localparam int XW   = $clog2(MAX_COLS);
  localparam int YW   = $clog2(MAX_ROWS);
  localparam int CHW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CLW  = ($clog2(MAX_COLS + 1) > 11) ? $clog2(MAX_COLS + 1) : 11;
  localparam int RLW  = ($clog2(MAX_ROWS + 1) > 11) ? $clog2(MAX_ROWS + 1) : 11;
  localparam int CCLW = ($clog2(MAX_CHANNELS + 1) > 13) ? $clog2(MAX_CHANNELS + 1) : 13;
  localparam int OCW  = (XW > 10) ? XW : 10;
  localparam int ORW  = (YW > 10) ? YW : 10;

  // Configuration registers
  logic [10:0] in_cols_q, in_rows_q;
  logic [9:0]  out_cols_q, out_rows_q;
  logic [12:0] channel_count_q;
  logic [1:0]  pool_stride_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cols_q       <= 11'd3;
      in_rows_q       <= 11'd3;
      out_cols_q      <= 10'd1;
      out_rows_q      <= 10'd1;
      channel_count_q <= 13'd1;
      pool_stride_q   <= 2'd1;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_IN_COLS:  in_cols_q       <= pwdata[10:0];
        REG_IN_ROWS:  in_rows_q       <= pwdata[10:0];
        REG_OUT_COLS: out_cols_q      <= pwdata[9:0];
        REG_OUT_ROWS: out_rows_q      <= pwdata[9:0];
        REG_CHANNELS: channel_count_q <= pwdata[12:0];
        REG_STRIDE: begin
          if (pwdata[1:0] != 2'd0) pool_stride_q <= pwdata[1:0];
        end
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (paddr[4:2])
      REG_IN_COLS:  prdata = {21'd0, in_cols_q};
      REG_IN_ROWS:  prdata = {21'd0, in_rows_q};
      REG_OUT_COLS: prdata = {22'd0, out_cols_q};
      REG_OUT_ROWS: prdata = {22'd0, out_rows_q};
      REG_CHANNELS: prdata = {19'd0, channel_count_q};
      REG_STRIDE:   prdata = {30'd0, pool_stride_q};
      default:      prdata = 32'd0;
    endcase
  end

  // Clamped geometry
  logic [CLW-1:0]  cols_c, in_cols_ext;
  logic [RLW-1:0]  rows_c, in_rows_ext;
  logic [CCLW-1:0] chans_c, chan_cnt_ext;

  assign in_cols_ext  = CLW'(in_cols_q);
  assign in_rows_ext  = RLW'(in_rows_q);
  assign chan_cnt_ext = CCLW'(channel_count_q);

  always_comb begin
    if (in_cols_ext < CLW'(3)) cols_c = CLW'(3);
    else if (in_cols_ext > CLW'(MAX_COLS)) cols_c = CLW'(MAX_COLS);
    else cols_c = in_cols_ext;
    if (in_rows_ext < RLW'(3)) rows_c = RLW'(3);
    else if (in_rows_ext > RLW'(MAX_ROWS)) rows_c = RLW'(MAX_ROWS);
    else rows_c = in_rows_ext;
    if (chan_cnt_ext < CCLW'(1)) chans_c = CCLW'(1);
    else if (chan_cnt_ext > CCLW'(MAX_CHANNELS)) chans_c = CCLW'(MAX_CHANNELS);
    else chans_c = chan_cnt_ext;
  end

  // Position state: column, row, channel, plus mod-3 trackers of x-2 and y-2
  logic [XW-1:0]  x_q, x_d, x0, xq3_q, xq3_d, xq3_0;
  logic [1:0]     xm3_q, xm3_d, xm3_0;
  logic [YW-1:0]  y_q, y_d, y0, yq3_q, yq3_d, yq3_0;
  logic [1:0]     ym3_q, ym3_d, ym3_0;
  logic [CHW-1:0] ch_q, ch_d, ch0;
  logic           in_accept;

  logic [XW-1:0]  dx, ocol;
  logic [YW-1:0]  dy, orow;
  logic           col_hit, row_hit, col_last, row_last, emit;
  logic           row_wrap, chan_wrap;

  assign in_accept = in_valid_i && in_ready_o;

  always_comb begin
    // wrap positions left beyond the current geometry
    x0 = x_q; xq3_0 = xq3_q; xm3_0 = xm3_q;
    if (CLW'(x_q) >= cols_c) begin
      x0 = '0; xq3_0 = '0; xm3_0 = 2'd0;
    end
    y0 = y_q; yq3_0 = yq3_q; ym3_0 = ym3_q;
    if (RLW'(y_q) >= rows_c) begin
      y0 = '0; yq3_0 = '0; ym3_0 = 2'd0;
    end
    ch0 = ch_q;
    if (CCLW'(ch_q) >= chans_c) ch0 = '0;

    dx = x0 - XW'(2);
    dy = y0 - YW'(2);
    case (pool_stride_q)
      2'd2: begin
        col_hit = !dx[0]; ocol = dx >> 1;
        row_hit = !dy[0]; orow = dy >> 1;
      end
      2'd3: begin
        col_hit = (xm3_0 == 2'd0); ocol = xq3_0;
        row_hit = (ym3_0 == 2'd0); orow = yq3_0;
      end
      default: begin
        col_hit = 1'b1; ocol = dx;
        row_hit = 1'b1; orow = dy;
      end
    endcase
    col_hit = col_hit && (x0 >= XW'(2)) && (OCW'(ocol) < OCW'(out_cols_q));
    row_hit = row_hit && (y0 >= YW'(2)) && (ORW'(orow) < ORW'(out_rows_q));
    emit    = col_hit && row_hit;
    // last window of a row: count reached, or the next window would not fit
    col_last = (OCW'(ocol) == OCW'(out_cols_q) - OCW'(1)) ||
               ((CLW + 1)'(x0) + (CLW + 1)'(pool_stride_q) >= (CLW + 1)'(cols_c));
    row_last = (ORW'(orow) == ORW'(out_rows_q) - ORW'(1)) ||
               ((RLW + 1)'(y0) + (RLW + 1)'(pool_stride_q) >= (RLW + 1)'(rows_c));

    // advance
    row_wrap  = ((CLW + 1)'(x0) + (CLW + 1)'(1) >= (CLW + 1)'(cols_c));
    chan_wrap = ((RLW + 1)'(y0) + (RLW + 1)'(1) >= (RLW + 1)'(rows_c));
    x_d = x0 + XW'(1); xq3_d = xq3_0; xm3_d = xm3_0;
    y_d = y0;          yq3_d = yq3_0; ym3_d = ym3_0;
    ch_d = ch0;
    if (x0 >= XW'(2)) begin
      xm3_d = (xm3_0 == 2'd2) ? 2'd0 : xm3_0 + 2'd1;
      if (xm3_0 == 2'd2) xq3_d = xq3_0 + XW'(1);
    end
    if (row_wrap) begin
      x_d = '0; xq3_d = '0; xm3_d = 2'd0;
      y_d = y0 + YW'(1);
      if (y0 >= YW'(2)) begin
        ym3_d = (ym3_0 == 2'd2) ? 2'd0 : ym3_0 + 2'd1;
        if (ym3_0 == 2'd2) yq3_d = yq3_0 + YW'(1);
      end
      if (chan_wrap) begin
        y_d = '0; yq3_d = '0; ym3_d = 2'd0;
        ch_d = ((CCLW + 1)'(ch0) + (CCLW + 1)'(1) >= (CCLW + 1)'(chans_c)) ?
               '0 : ch0 + CHW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0; xq3_q <= '0; xm3_q <= 2'd0;
      y_q <= '0; yq3_q <= '0; ym3_q <= 2'd0;
      ch_q <= '0;
    end else if (in_accept) begin
      x_q <= x_d; xq3_q <= xq3_d; xm3_q <= xm3_d;
      y_q <= y_d; yq3_q <= yq3_d; ym3_q <= ym3_d;
      ch_q <= ch_d;
    end
  end

  // Stage 1: read data arrives, column maximum and write-back
  logic          s1_valid_q;
  logic [31:0]   s1_sample_q;
  logic [XW-1:0] s1_x_q;
  logic          s1_emit_q, s1_re_q, s1_ce_q;
  logic [31:0]   hist0_q, hist1_q;
  logic [63:0]   line_rd;
  logic [31:0]   colmax, winmax;
  logic [1:0]    fifo_count;
  mp3_result_t   push_res, out_res;
  logic          fifo_push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_sample_q <= sample_bits_i;
      s1_x_q      <= x0;
      s1_emit_q   <= emit;
      s1_re_q     <= col_last;
      s1_ce_q     <= col_last && row_last;
    end
  end

  mp3_line_mem #(
    .DEPTH(MAX_COLS),
    .AW   (XW)
  ) u_line_mem (
    .clk_i    (clk_i),
    .rd_en_i  (in_accept),
    .rd_addr_i(x0),
    .rd_data_o(line_rd),
    .wr_en_i  (s1_valid_q),
    .wr_addr_i(s1_x_q),
    .wr_data_i({line_rd[31:0], s1_sample_q})
  );

  assign colmax = fmax_bits(fmax_bits(line_rd[63:32], line_rd[31:0]), s1_sample_q);
  assign winmax = fmax_bits(fmax_bits(hist1_q, hist0_q), colmax);

  // Column maximum history of the two previous columns
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist0_q <= 32'd0;
      hist1_q <= 32'd0;
    end else if (s1_valid_q) begin
      hist1_q <= hist0_q;
      hist0_q <= colmax;
    end
  end

  assign fifo_push            = s1_valid_q && s1_emit_q;
  assign push_res.max_bits    = winmax;
  assign push_res.row_end     = s1_re_q;
  assign push_res.channel_end = s1_ce_q;

  // Room for the in-flight stage 1 result and this one
  assign in_ready_o = ({1'b0, fifo_count} + {2'd0, s1_valid_q}) <= 3'd2;

  mp3_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (fifo_push),
    .push_data_i(push_res),
    .count_o    (fifo_count),
    .valid_o    (out_valid_o),
    .ready_i    (out_ready_i),
    .data_o     (out_res)
  );

  assign max_bits_o    = out_res.max_bits;
  assign row_end_o     = out_res.row_end;
  assign channel_end_o = out_res.channel_end;

  `MP3_ASSERT(a_no_rw_collision, clk_i, rst_ni, (s1_valid_q && in_accept) |-> (s1_x_q != x0))
  `MP3_ASSERT(a_chan_end_is_row_end, clk_i, rst_ni,
              (out_valid_o && channel_end_o) |-> row_end_o)
  `MP3_ASSERT(a_stride_nonzero, clk_i, rst_ni, cfg_wr |=> (pool_stride_q != 2'd0))

endmodule
`default_nettype wire
